/* design/bsm_pkg.sv */
// Shared types and constants for the 3x3 edge-clamped box smoother.
// Used by the sequencer, the averaging datapath and the top level.
`timescale 1ns / 1ps

package bsm_pkg;

    localparam int MAX_SIDE_DEF     = 1024;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int FRAME_SIZE_W     = 11;
    localparam int CHAN_W           = 16;
    localparam int COORD_W          = 10;
    localparam int FRAME_SIZE_RST   = 1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COL,
        ST_TOT,
        ST_MUL,
        ST_OUT
    } seq_state_t;

    // Strobes and window masks from the sequencer to the datapath.
    typedef struct packed {
        logic       capture;
        logic       load;
        logic       col_en;
        logic       tot_en;
        logic       mul_en;
        logic       out_load;
        logic [2:0] row_mask;
        logic [2:0] col_mask;
    } ctrl_t;

endpackage

/* design/box_smooth_3x3_edge_clamped_top.sv */
// Channel    | Signals                                       | Direction
// config     | cfg_wr_en, cfg_wr_data                        | in
// pixel in   | in_valid, in_stall, red/green/blue_in         | in (stall out)
// result out | out_valid, out_stall, red/green/blue_out,     | out (stall in)
//            | out_row, out_col, last_of_run                 |
//
// A pixel is accepted and then its line-buffer entry is read. The sequencer then
// walks each result it produces (none, one for an interior pixel, up to four at
// the last pixel of the frame) through column sums, total, reciprocal multiply
// and output load in turn.
// The output register lets the next pixel in while the last result waits.
// A stalled output holds the sequencer in its output step. Reset needs no clearing pass.
// Depends on bsm_pkg, bsm_ram, bsm_seq and bsm_avg.
`timescale 1ns / 1ps

module box_smooth_3x3_edge_clamped_top
    import bsm_pkg::*;
#(
    parameter int MAX_SIDE     = MAX_SIDE_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [FRAME_SIZE_W-1:0] cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CHAN_W-1:0]       red_in,
    input  logic [CHAN_W-1:0]       green_in,
    input  logic [CHAN_W-1:0]       blue_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [CHAN_W-1:0]       red_out,
    output logic [CHAN_W-1:0]       green_out,
    output logic [CHAN_W-1:0]       blue_out,
    output logic [COORD_W-1:0]      out_row,
    output logic [COORD_W-1:0]      out_col,
    output logic                    last_of_run
);

    localparam int POS_W  = $clog2(MAX_SIDE);
    localparam int LINE_W = 6 * CHANNEL_BITS;

    ctrl_t             ctl;
    logic [POS_W-1:0]  wr_addr, rd_addr;
    logic [LINE_W-1:0] line_rd, line_wr;

    bsm_seq #(
        .MAX_SIDE(MAX_SIDE)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_row    (out_row),
        .out_col    (out_col),
        .last_of_run(last_of_run),
        .ctl        (ctl),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr)
    );

    // Both line buffers share one entry per column: {older row, newer row}.
    // The write-back of a column always lands before the next read is issued.
    bsm_ram #(
        .WIDTH(LINE_W),
        .DEPTH(MAX_SIDE)
    ) u_lines (
        .clk    (clk),
        .wr_en  (ctl.load),
        .wr_addr(wr_addr),
        .wr_data(line_wr),
        .rd_addr(rd_addr),
        .rd_data(line_rd)
    );

    bsm_avg #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_avg (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .line_rd  (line_rd),
        .line_wr  (line_wr),
        .red_out  (red_out),
        .green_out(green_out),
        .blue_out (blue_out)
    );

endmodule

/* design/bsm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module bsm_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/bsm_seq.sv */
// Sequencer of the box smoother: pixel position, frame size, result stepping,
// output coordinates and handshakes. Depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_seq
    import bsm_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [FRAME_SIZE_W-1:0]     cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [COORD_W-1:0]          out_row,
    output logic [COORD_W-1:0]          out_col,
    output logic                        last_of_run,
    output ctrl_t                       ctl,
    output logic [$clog2(MAX_SIDE)-1:0] wr_addr,
    output logic [$clog2(MAX_SIDE)-1:0] rd_addr
);

    localparam int POS_W    = $clog2(MAX_SIDE);
    localparam int CMP_W    = (POS_W + 1 > FRAME_SIZE_W) ? POS_W + 1 : FRAME_SIZE_W;
    localparam int EXT_W    = (POS_W > COORD_W) ? POS_W : COORD_W;
    localparam int RST_LAST = (FRAME_SIZE_RST > MAX_SIDE) ? MAX_SIDE - 1 : FRAME_SIZE_RST - 1;

    seq_state_t         state_reg, state_next;
    logic [POS_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [POS_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [POS_W-1:0]   r_reg, r_next;
    logic [POS_W-1:0]   c_reg, c_next;
    logic [POS_W-1:0]   last_reg, last_next;
    logic               a_reg, a_next;
    logic               b_reg, b_next;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_row_reg, out_row_next;
    logic [COORD_W-1:0] out_col_reg, out_col_next;
    logic               out_last_reg, out_last_next;

    logic [CMP_W-1:0]   fs_ext;
    logic [POS_W-1:0]   cfg_last;
    logic               one_pix;
    logic               rows_none, cols_none, rows_two, cols_two;
    logic               self_row, self_col, last_res, out_free;
    logic [POS_W-1:0]   res_row, res_col;
    logic [EXT_W-1:0]   row_ext, col_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            last_reg      <= POS_W'(RST_LAST);
            a_reg         <= 1'b0;
            b_reg         <= 1'b0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            last_reg      <= last_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            out_valid_reg <= out_valid_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Frame side clamped to 1..MAX_SIDE, kept as the index of the last pixel.
    always_comb
    begin
        fs_ext = CMP_W'(cfg_wr_data);
        if (fs_ext == '0)
        begin
            cfg_last = '0;
        end
        else if (fs_ext > CMP_W'(MAX_SIDE))
        begin
            cfg_last = POS_W'(MAX_SIDE - 1);
        end
        else
        begin
            cfg_last = POS_W'(fs_ext - CMP_W'(1));
        end
    end

    always_comb
    begin
        one_pix   = (last_reg == '0);
        rows_none = !one_pix && (r_reg == '0);
        cols_none = !one_pix && (c_reg == '0);
        rows_two  = !one_pix && (r_reg == last_reg);
        cols_two  = !one_pix && (c_reg == last_reg);
        // The second result along an axis, or a single-pixel image, is centered on
        // the current pixel itself rather than one behind it.
        self_row  = one_pix || a_reg;
        self_col  = one_pix || b_reg;
        res_row   = self_row ? r_reg : r_reg - POS_W'(1);
        res_col   = self_col ? c_reg : c_reg - POS_W'(1);
        row_ext   = EXT_W'(res_row);
        col_ext   = EXT_W'(res_col);
        last_res  = (a_reg == rows_two) && (b_reg == cols_two);
        out_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        last_next      = last_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && out_stall;

        ctl.capture  = 1'b0;
        ctl.load     = 1'b0;
        ctl.col_en   = 1'b0;
        ctl.tot_en   = 1'b0;
        ctl.mul_en   = 1'b0;
        ctl.out_load = 1'b0;
        ctl.row_mask = {1'b1, r_reg != '0, (r_reg > POS_W'(1)) && !self_row};
        ctl.col_mask = {1'b1, c_reg != '0, (c_reg > POS_W'(1)) && !self_col};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    r_next      = row_cnt_reg;
                    c_next      = col_cnt_reg;
                    state_next  = ST_LOAD;
                    if (col_cnt_reg == last_reg)
                    begin
                        col_cnt_next = '0;
                        row_cnt_next = (row_cnt_reg == last_reg) ? '0
                                                                 : row_cnt_reg + POS_W'(1);
                    end
                    else
                    begin
                        col_cnt_next = col_cnt_reg + POS_W'(1);
                    end
                end
            end
            ST_LOAD:
            begin
                ctl.load = 1'b1;
                a_next   = 1'b0;
                b_next   = 1'b0;
                if (rows_none || cols_none)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_COL;
                end
            end
            ST_COL:
            begin
                ctl.col_en = 1'b1;
                state_next = ST_TOT;
            end
            ST_TOT:
            begin
                ctl.tot_en = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                ctl.mul_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    out_row_next   = row_ext[COORD_W-1:0];
                    out_col_next   = col_ext[COORD_W-1:0];
                    out_last_next  = last_res;
                    if (last_res)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_COL;
                        if (cols_two && !b_reg)
                        begin
                            b_next = 1'b1;
                        end
                        else
                        begin
                            a_next = 1'b1;
                            b_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write restarts the frame at pixel (0,0).
        if (cfg_wr_en)
        begin
            row_cnt_next = '0;
            col_cnt_next = '0;
            last_next    = cfg_last;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign last_of_run = out_last_reg;
    assign wr_addr     = c_reg;
    assign rd_addr     = col_cnt_reg;

endmodule

/* design/bsm_avg.sv */
// Averaging datapath: window columns, masked sums, reciprocal multiply and the
// channel output registers. Depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_avg
    import bsm_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctrl_t                       ctl,
    input  logic [CHAN_W-1:0]           red_in,
    input  logic [CHAN_W-1:0]           green_in,
    input  logic [CHAN_W-1:0]           blue_in,
    input  logic [6*CHANNEL_BITS-1:0]   line_rd,
    output logic [6*CHANNEL_BITS-1:0]   line_wr,
    output logic [CHAN_W-1:0]           red_out,
    output logic [CHAN_W-1:0]           green_out,
    output logic [CHAN_W-1:0]           blue_out
);

    localparam int CB      = CHANNEL_BITS;
    localparam int PIX_W   = 3 * CB;
    localparam int COL_W   = CB + 2;
    localparam int SUM_W   = CB + 4;
    // Exact floor division for divisors up to 9 over SUM_W-bit dividends.
    localparam int SHIFT   = SUM_W + 4;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(1 << SHIFT);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(((1 << SHIFT) + 1) / 2);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((1 << SHIFT) + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(((1 << SHIFT) + 3) / 4);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((1 << SHIFT) + 5) / 6);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << SHIFT) + 8) / 9);

    // Window index order: [column][row][channel]; column 2 and row 2 are newest.
    logic [CB-1:0]      pix_reg    [3];
    logic [CB-1:0]      col_m2_reg [3][3];
    logic [CB-1:0]      col_m1_reg [3][3];
    logic [CB-1:0]      win_reg    [3][3][3];
    logic [CB-1:0]      new_col    [3][3];
    logic [COL_W-1:0]   colsum_reg [3][3];
    logic [COL_W-1:0]   colsum_next[3][3];
    logic [SUM_W-1:0]   total_reg  [3];
    logic [SUM_W-1:0]   total_next [3];
    logic [PROD_W-1:0]  prod_reg   [3];
    logic [3:0]         cnt_reg, cnt_next;
    logic [RECIP_W-1:0] recip_reg, recip_next;
    logic [1:0]         rows_n, cols_n;
    logic [CHAN_W-1:0]  red_out_reg, green_out_reg, blue_out_reg;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            new_col[0][ch] = line_rd[PIX_W + ch*CB +: CB];
            new_col[1][ch] = line_rd[ch*CB +: CB];
            new_col[2][ch] = pix_reg[ch];
        end
        line_wr = {line_rd[PIX_W-1:0], pix_reg[2], pix_reg[1], pix_reg[0]};
    end

    always_comb
    begin
        rows_n   = 2'(ctl.row_mask[0]) + 2'(ctl.row_mask[1]) + 2'(ctl.row_mask[2]);
        cols_n   = 2'(ctl.col_mask[0]) + 2'(ctl.col_mask[1]) + 2'(ctl.col_mask[2]);
        cnt_next = 4'(rows_n) * 4'(cols_n);
        for (int m = 0; m < 3; m++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                colsum_next[m][ch] =
                    (ctl.row_mask[0] ? COL_W'(win_reg[m][0][ch]) : '0) +
                    (ctl.row_mask[1] ? COL_W'(win_reg[m][1][ch]) : '0) +
                    (ctl.row_mask[2] ? COL_W'(win_reg[m][2][ch]) : '0);
            end
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            total_next[ch] =
                (ctl.col_mask[0] ? SUM_W'(colsum_reg[0][ch]) : '0) +
                (ctl.col_mask[1] ? SUM_W'(colsum_reg[1][ch]) : '0) +
                (ctl.col_mask[2] ? SUM_W'(colsum_reg[2][ch]) : '0);
        end
        case (cnt_reg)
            4'd2:    recip_next = RECIP_2;
            4'd3:    recip_next = RECIP_3;
            4'd4:    recip_next = RECIP_4;
            4'd6:    recip_next = RECIP_6;
            4'd9:    recip_next = RECIP_9;
            default: recip_next = RECIP_1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    col_m2_reg[k][ch] <= '0;
                    col_m1_reg[k][ch] <= '0;
                end
            end
        end
        else if (ctl.load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    col_m2_reg[k][ch] <= col_m1_reg[k][ch];
                    col_m1_reg[k][ch] <= new_col[k][ch];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            pix_reg[0] <= red_in[CB-1:0];
            pix_reg[1] <= green_in[CB-1:0];
            pix_reg[2] <= blue_in[CB-1:0];
        end
        if (ctl.load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    win_reg[0][k][ch] <= col_m2_reg[k][ch];
                    win_reg[1][k][ch] <= col_m1_reg[k][ch];
                    win_reg[2][k][ch] <= new_col[k][ch];
                end
            end
        end
        if (ctl.col_en)
        begin
            colsum_reg <= colsum_next;
            cnt_reg    <= cnt_next;
        end
        if (ctl.tot_en)
        begin
            total_reg <= total_next;
            recip_reg <= recip_next;
        end
        if (ctl.mul_en)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                prod_reg[ch] <= PROD_W'(total_reg[ch]) * PROD_W'(recip_reg);
            end
        end
        if (ctl.out_load)
        begin
            red_out_reg   <= CHAN_W'(prod_reg[0][SHIFT +: CB]);
            green_out_reg <= CHAN_W'(prod_reg[1][SHIFT +: CB]);
            blue_out_reg  <= CHAN_W'(prod_reg[2][SHIFT +: CB]);
        end
    end

    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;

endmodule

/* design/bsm_checker.sv */
// Port-level checks for the box smoother, bound to the top level.
// Depends on bsm_pkg for field widths.
`timescale 1ns / 1ps

module bsm_checker
    import bsm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    cfg_wr_en,
    input logic [FRAME_SIZE_W-1:0] cfg_wr_data,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic [CHAN_W-1:0]       red_in,
    input logic [CHAN_W-1:0]       green_in,
    input logic [CHAN_W-1:0]       blue_in,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [CHAN_W-1:0]       red_out,
    input logic [CHAN_W-1:0]       green_out,
    input logic [CHAN_W-1:0]       blue_out,
    input logic [COORD_W-1:0]      out_row,
    input logic [COORD_W-1:0]      out_col,
    input logic                    last_of_run
);

    // A stalled result transaction keeps its valid and payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(out_row) && $stable(out_col)
            && $stable(last_of_run))
        else $error("stalled result changed");

    // Pixels are processed one at a time.
    a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    // While a pixel still owes results, no new pixel may enter.
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> in_stall)
        else $error("input open in the middle of a result run");

    // A new result only appears while a pixel is being worked on.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a pixel in flight");

endmodule

bind box_smooth_3x3_edge_clamped_top bsm_checker u_bsm_checker (.*);
